// ===== rtl/jslc_pkg.sv =====
`default_nettype none

package jslc_pkg;

    localparam int unsigned DEPTH_W   = 8;
    localparam int unsigned STRLIM_W  = 16;
    localparam int unsigned DOCLIM_W  = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;

    // counters are one bit wider than their limits so they can sit one past
    localparam int unsigned NEST_W = DEPTH_W + 1;
    localparam int unsigned SBYTES_W = STRLIM_W + 1;
    localparam int unsigned DBYTES_W = DOCLIM_W + 1;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRING_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INPUT_BYTES  = 2'd2;

    localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH        = 8'd64;
    localparam logic [STRLIM_W-1:0] RST_MAX_STRING_BYTES = 16'd4096;
    localparam logic [DOCLIM_W-1:0] RST_MAX_INPUT_BYTES  = 24'd1048576;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NUL       = 3'd3,
        ST_DEPTH     = 3'd4,
        ST_STRING    = 3'd5
    } status_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]  max_depth;
        logic [STRLIM_W-1:0] max_string_bytes;
        logic [DOCLIM_W-1:0] max_input_bytes;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/jslc_cfg_regs.sv =====
`default_nettype none

module jslc_cfg_regs
    import jslc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_DEPTH: begin
                    cfg_next.max_depth = cfg_data[DEPTH_W-1:0];
                end
                CFG_MAX_STRING_BYTES: begin
                    cfg_next.max_string_bytes = cfg_data[STRLIM_W-1:0];
                end
                CFG_MAX_INPUT_BYTES: begin
                    cfg_next.max_input_bytes = cfg_data[DOCLIM_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg; // unknown index: dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_depth        <= RST_MAX_DEPTH;
            cfg_reg.max_string_bytes <= RST_MAX_STRING_BYTES;
            cfg_reg.max_input_bytes  <= RST_MAX_INPUT_BYTES;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jslc_scan.sv =====
`default_nettype none

module jslc_scan
    import jslc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_doc,
    input  wire logic       no_byte,
    input  cfg_t            cfg,
    output status_t         status
);

    logic                inside_string_reg, inside_string_next;
    logic                escape_pending_reg, escape_pending_next;
    logic [NEST_W-1:0]   nest_level_reg, nest_level_next;
    logic [SBYTES_W-1:0] string_bytes_reg, string_bytes_next;
    logic [DBYTES_W-1:0] doc_bytes_reg, doc_bytes_next;
    status_t             fault_reg, fault_next;

    logic [SBYTES_W-1:0] sb_inc;
    logic [NEST_W-1:0]   nest_inc;
    logic                str_over;
    logic                depth_over;
    logic                count_byte;

    assign sb_inc     = string_bytes_reg + SBYTES_W'(1);
    assign nest_inc   = nest_level_reg + NEST_W'(1);
    assign str_over   = sb_inc > {1'b0, cfg.max_string_bytes};
    assign depth_over = nest_inc > {1'b0, cfg.max_depth};

    always_comb begin
        inside_string_next  = inside_string_reg;
        escape_pending_next = escape_pending_reg;
        nest_level_next     = nest_level_reg;
        string_bytes_next   = string_bytes_reg;
        doc_bytes_next      = doc_bytes_reg;
        fault_next          = fault_reg;
        count_byte          = 1'b0;

        if (!no_byte) begin
            // saturates at one past the limit
            if (doc_bytes_reg <= {1'b0, cfg.max_input_bytes}) begin
                doc_bytes_next = doc_bytes_reg + DBYTES_W'(1);
            end
            if (fault_reg == ST_OK) begin
                if (data_byte == CH_NUL) begin
                    fault_next = ST_NUL;
                end else if (inside_string_reg) begin
                    if (escape_pending_reg) begin
                        escape_pending_next = 1'b0;
                        count_byte          = 1'b1;
                    end else if (data_byte == CH_BACKSLASH) begin
                        escape_pending_next = 1'b1;
                        count_byte          = 1'b1;
                    end else if (data_byte == CH_QUOTE) begin
                        inside_string_next = 1'b0;
                    end else begin
                        count_byte = 1'b1;
                    end
                end else if (data_byte == CH_QUOTE) begin
                    inside_string_next  = 1'b1;
                    escape_pending_next = 1'b0;
                    string_bytes_next   = '0;
                end else if (data_byte == CH_LBRACE || data_byte == CH_LBRACKET) begin
                    nest_level_next = nest_inc;
                    if (depth_over) begin
                        fault_next = ST_DEPTH;
                    end
                end else if ((data_byte == CH_RBRACE || data_byte == CH_RBRACKET)
                             && nest_level_reg != '0) begin
                    nest_level_next = nest_level_reg - NEST_W'(1);
                end
                if (count_byte) begin
                    string_bytes_next = sb_inc;
                    if (str_over) begin
                        fault_next = ST_STRING;
                    end
                end
            end
        end

        if (doc_bytes_next == '0) begin
            status = ST_EMPTY;
        end else if (doc_bytes_next > {1'b0, cfg.max_input_bytes}) begin
            status = ST_TOO_LARGE;
        end else begin
            status = fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_doc)) begin
            inside_string_reg  <= 1'b0;
            escape_pending_reg <= 1'b0;
            nest_level_reg     <= '0;
            string_bytes_reg   <= '0;
            doc_bytes_reg      <= '0;
            fault_reg          <= ST_OK;
        end else if (step) begin
            inside_string_reg  <= inside_string_next;
            escape_pending_reg <= escape_pending_next;
            nest_level_reg     <= nest_level_next;
            string_bytes_reg   <= string_bytes_next;
            doc_bytes_reg      <= doc_bytes_next;
            fault_reg          <= fault_next;
        end
    end

    a_escape_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        escape_pending_reg |-> inside_string_reg)
        else $error("escape pending outside a string");

    a_nest_top_is_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        nest_level_reg[NEST_W-1] |-> fault_reg == ST_DEPTH)
        else $error("nesting reached its top without a depth fault");

    a_string_top_is_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        string_bytes_reg[SBYTES_W-1] |-> fault_reg == ST_STRING)
        else $error("string count reached its top without a string fault");

endmodule

`default_nettype wire

// ===== rtl/json_structure_limit_checker_core.sv =====
// Result path: the transaction carrying end_of_doc is held in the input register, and its
//   status then goes to the result register, which drives m_valid.
// Throughput: one byte per cycle; only an end_of_doc transaction held behind an
//   unaccepted status stalls the input side.
// Reset: synchronous, active low; limits return to 64 / 4096 / 1048576, all document
//   state clears and the valid bits of both pipeline registers clear.
`default_nettype none

module json_structure_limit_checker_core
    import jslc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_end_of_doc,
    input  wire logic                 s_no_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_status
);

    cfg_t    cfg;
    status_t status;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       in_none_reg;
    logic       consume;

    logic       out_valid_reg, out_valid_next;
    status_t    status_reg;

    jslc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // an item with no result never waits on the result side
    assign consume = in_valid_reg && (!in_end_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || consume;

    jslc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (consume),
        .data_byte  (in_byte_reg),
        .end_of_doc (in_end_reg),
        .no_byte    (in_none_reg),
        .cfg        (cfg),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_end_of_doc;
            in_none_reg <= s_no_byte;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (consume && in_end_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_end_reg) begin
            status_reg <= status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = status_reg;

    a_result_from_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(consume && in_end_reg))
        else $error("result raised without an end-of-document transaction");

    a_plain_byte_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_end_reg) |-> s_ready)
        else $error("byte without a result stalled the input");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_end_reg) |=> out_valid_reg)
        else $error("end-of-document transaction lost its result");

endmodule

`default_nettype wire

// ===== dv/jslc_status_checker.sv =====
module jslc_status_checker
    import jslc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_end_of_doc,
    input  wire logic                 s_no_byte,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [2:0]           m_status,
    output int                        mismatches,
    output int                        status_pending,
    output int                        statuses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                limits;
    logic                in_str;
    logic                esc;
    logic [NEST_W-1:0]   depth;
    logic [SBYTES_W-1:0] str_len;
    logic [DBYTES_W-1:0] doc_len;
    status_t             fault;
    status_t             want;
    status_t             status_due[$];

    function void drop_document();
        in_str  = 1'b0;
        esc     = 1'b0;
        depth   = '0;
        str_len = '0;
        doc_len = '0;
        fault   = ST_OK;
    endfunction

    function void add_string_byte();
        str_len++;
        if (str_len > limits.max_string_bytes)
            fault = ST_STRING;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            limits.max_depth        = RST_MAX_DEPTH;
            limits.max_string_bytes = RST_MAX_STRING_BYTES;
            limits.max_input_bytes  = RST_MAX_INPUT_BYTES;
            drop_document();
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_DEPTH:        limits.max_depth        = cfg_data[DEPTH_W-1:0];
                    CFG_MAX_STRING_BYTES: limits.max_string_bytes = cfg_data[STRLIM_W-1:0];
                    CFG_MAX_INPUT_BYTES:  limits.max_input_bytes  = cfg_data[DOCLIM_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (!s_no_byte) begin
                    // saturates one past the limit
                    if (doc_len <= limits.max_input_bytes)
                        doc_len++;
                    // once a fault is latched the rest of the document is only counted
                    if (fault == ST_OK) begin
                        if (s_data_byte == CH_NUL) begin
                            fault = ST_NUL;
                        end else if (in_str) begin
                            if (esc) begin
                                esc = 1'b0;
                                add_string_byte();
                            end else if (s_data_byte == CH_BACKSLASH) begin
                                esc = 1'b1;
                                add_string_byte();
                            end else if (s_data_byte == CH_QUOTE) begin
                                in_str = 1'b0;
                            end else begin
                                add_string_byte();
                            end
                        end else if (s_data_byte == CH_QUOTE) begin
                            in_str  = 1'b1;
                            esc     = 1'b0;
                            str_len = '0;
                        end else if (s_data_byte == CH_LBRACE || s_data_byte == CH_LBRACKET) begin
                            depth++;
                            if (depth > limits.max_depth)
                                fault = ST_DEPTH;
                        end else if ((s_data_byte == CH_RBRACE || s_data_byte == CH_RBRACKET)
                                     && depth != 0) begin
                            depth--;
                        end
                    end
                end
                if (s_end_of_doc) begin
                    if (doc_len == 0)
                        status_due.push_back(ST_EMPTY);
                    else if (doc_len > limits.max_input_bytes)
                        status_due.push_back(ST_TOO_LARGE);
                    else
                        status_due.push_back(fault);
                    drop_document();
                end
            end

            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: status with nothing outstanding, expected none, actual %0d",
                             $time, m_status);
                end else begin
                    want = status_due.pop_front();
                    statuses_seen++;
                    if (m_status !== want) begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                                 $time, want, want.name(), m_status);
                    end
                end
            end
        end
        status_pending = status_due.size();
    end

endmodule

// ===== dv/tb_json_structure_limit_checker_core.sv =====
module tb_json_structure_limit_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jslc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 650;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_end_of_doc;
    logic                 s_no_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;

    int mismatches;
    int status_pending;
    int statuses_seen;

    logic [7:0] doc_text[$];
    int         items_sent = 0;
    int         docs_sent  = 0;
    int         limit_sets = 0;
    bit         no_idle    = 1'b0;
    int         rx_hold_req = 0;

    json_structure_limit_checker_core dut (.*);

    jslc_status_checker status_chk (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // all tasks below are entered and left just after a falling edge
    task automatic send_item(input logic [7:0] b, input logic e, input logic nb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_end_of_doc <= e;
        s_no_byte    <= nb;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (e || !nb)
            items_sent++;
        if (e)
            docs_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], i == txt.len() - 1, 1'b0);
    endtask

    // sprinkles ignored transactions in and closes either on the last byte or separately
    task automatic send_doc();
        int n;
        bit on_byte;
        n = doc_text.size();
        on_byte = 1'($urandom_range(0, 1));
        foreach (doc_text[i]) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom()), 1'b0, 1'b1);
            send_item(doc_text[i], on_byte && (i == n - 1), 1'b0);
        end
        if (!on_byte || n == 0)
            send_item(8'($urandom()), 1'b1, 1'b1);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // bits above each register's width carry noise
    task automatic set_limits(input logic [DEPTH_W-1:0] dep,
                              input logic [STRLIM_W-1:0] str_max,
                              input logic [DOCLIM_W-1:0] doc_max);
        logic [CFG_DAT_W-1:0] d;
        d = CFG_DAT_W'($urandom());
        d[DEPTH_W-1:0] = dep;
        write_limit(CFG_MAX_DEPTH, d);
        d = CFG_DAT_W'($urandom());
        d[STRLIM_W-1:0] = str_max;
        write_limit(CFG_MAX_STRING_BYTES, d);
        write_limit(CFG_MAX_INPUT_BYTES, doc_max);
        write_limit(CFG_UNUSED_IDX, CFG_DAT_W'($urandom()));
        cfg_valid <= 1'b0;
        limit_sets++;
    endtask

    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (status_pending != 0);
        repeat (settle) @(negedge aclk);
    endtask

    // mostly JSON-shaped text: nesting, quoted strings with escapes, filler, rare NULs
    function automatic void gen_doc(input int tokens);
        int          depth_open;
        int          len;
        int unsigned pick;
        logic [7:0]  c;
        doc_text.delete();
        depth_open = 0;
        repeat (tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                doc_text.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
                depth_open++;
            end else if (pick < 45) begin
                doc_text.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
                if (depth_open > 0)
                    depth_open--;
            end else if (pick < 75) begin
                doc_text.push_back(CH_QUOTE);
                len = $urandom_range(0, 7);
                repeat (len) begin
                    if ($urandom_range(0, 5) == 0) begin
                        doc_text.push_back(CH_BACKSLASH);
                        c = 8'($urandom_range(1, 255));
                        doc_text.push_back(c);
                    end else begin
                        c = 8'($urandom_range(1, 255));
                        if (c == CH_QUOTE || c == CH_BACKSLASH)
                            c = 8'h61;
                        doc_text.push_back(c);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    doc_text.push_back(CH_QUOTE);
            end else if (pick < 95) begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                doc_text.push_back(c);
            end else if (pick < 97) begin
                doc_text.push_back(CH_NUL);
            end else begin
                c = 8'($urandom_range(0, 255));
                doc_text.push_back(c);
            end
        end
        while (depth_open > 0 && $urandom_range(0, 7) != 0) begin
            doc_text.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
            depth_open--;
        end
    endfunction

    initial begin : receiver
        int wait_n;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_req != 0) begin
                wait_n = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                wait_n = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (wait_n != 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("json_structure_limit_checker_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int  phase_n;
        int  sel;
        int  random_base;
        bit  deep_done;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_end_of_doc = 1'b0;
        s_no_byte    = 1'b0;
        phase_n      = 0;
        deep_done    = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: tight limits so every status shows up in a few bytes
        set_limits(8'd2, 16'd3, 24'd7);
        send_item(8'hFF, 1'b1, 1'b1);          // empty document
        send_item(CH_NUL, 1'b0, 1'b1);         // no byte, no close: ignored
        send_text("]{\"\\\"\"}");              // stray closer, escaped quote, exactly at size limit
        send_text("[[[");                      // one level too deep
        send_text("\"abcd\"");                 // one byte over the string limit
        send_item(CH_NUL, 1'b0, 1'b0);
        send_item(CH_LBRACE, 1'b1, 1'b0);      // NUL, later bytes not scanned
        send_item(CH_NUL, 1'b0, 1'b0);         // oversize wins over the latched NUL
        repeat (6) send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        wait_idle(4);

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            sel = phase_n % 7;
            no_idle = (phase_n % 3 == 2);
            case (sel)
                0:       set_limits(8'd0, 16'd0, 24'd1);
                1:       set_limits(8'd255, 16'hFFFF, 24'hFFFFFF);
                2:       set_limits(8'd3, 16'd5, 24'd40);
                3:       set_limits(DEPTH_W'($urandom()), STRLIM_W'($urandom()),
                                    DOCLIM_W'($urandom_range(10, 80)));
                4:       set_limits(8'd1, 16'd2, 24'd0);
                5:       set_limits(RST_MAX_DEPTH, RST_MAX_STRING_BYTES, RST_MAX_INPUT_BYTES);
                default: set_limits(DEPTH_W'($urandom_range(1, 6)),
                                    STRLIM_W'($urandom_range(0, 10)),
                                    DOCLIM_W'($urandom_range(5, 60)));
            endcase

            if (sel == 1 && !deep_done) begin
                // nest right up to the widest limit without tripping it
                doc_text.delete();
                repeat (255) doc_text.push_back(CH_LBRACKET);
                doc_text.push_back(CH_RBRACKET);
                doc_text.push_back(CH_LBRACE);
                send_doc();
                deep_done = 1'b1;
            end

            if (sel == 2) begin
                // receiver holds off; one-byte and empty documents pile up until the input stalls
                rx_hold_req = 80;
                repeat (12) send_item(8'($urandom()), 1'b1, 1'($urandom_range(0, 1)));
                wait_idle(0);
            end

            repeat (6) begin
                gen_doc(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12));
                send_doc();
            end
            wait_idle(4);
            phase_n++;
        end

        wait_idle(8);
        $display("covered %0d transactions in %0d documents over %0d limit settings",
                 items_sent, docs_sent, limit_sets);
        $display("%0d statuses compared, including input stall under receiver hold-off",
                 statuses_seen);
        if (mismatches == 0 && status_pending == 0) begin
            $display("json_structure_limit_checker_core regression: pass");
        end else begin
            $display("json_structure_limit_checker_core regression: fail");
        end
        $finish;
    end

endmodule
